>>> rtl/chbt_pkg.sv
// shared constants, codes and interface types for the chained hash bucket table
package chbt_pkg;

    localparam int MAX_BUCKETS = 16;
    localparam int SLOTS       = 8;
    localparam int KEY_W       = 31;
    localparam int BUCKET_W    = $clog2(MAX_BUCKETS);
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int FILL_W      = $clog2(SLOTS + 1);
    localparam int ADDR_W      = BUCKET_W + SLOT_W;
    localparam int DEPTH       = MAX_BUCKETS * SLOTS;
    localparam int CNT_W       = 5;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int DIV_W       = BUCKET_W + 1;
    localparam int MOD_STEPS   = (KEY_W + 1) / 2;
    localparam int STEP_W      = $clog2(MOD_STEPS);

    localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = CNT_W'(7);

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic              start;
        logic [KEY_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic                done;
        logic [BUCKET_W-1:0] rem;
    } mod_rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

>>> rtl/chbt_mod_unit.sv
// iterative key modulo bucket count, two remainder bits per cycle
module chbt_mod_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  chbt_pkg::mod_req_t req,
    output chbt_pkg::mod_rsp_t rsp
);
    import chbt_pkg::*;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [KEY_W:0]      shift_reg, shift_next;
    logic [BUCKET_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic                done_reg, done_next;
    logic [DIV_W-1:0]    t1, t2;
    logic [BUCKET_W-1:0] r1;

    always_comb
    begin
        t1 = {rem_reg, shift_reg[KEY_W]};
        if (t1 >= div_reg)
        begin
            t1 = t1 - div_reg;
        end
        r1 = t1[BUCKET_W-1:0];
        t2 = {r1, shift_reg[KEY_W-1]};
        if (t2 >= div_reg)
        begin
            t2 = t2 - div_reg;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = {1'b0, req.dividend};
            rem_next   = '0;
            div_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[KEY_W-2:0], 2'b00};
            rem_next   = t2[BUCKET_W-1:0];
            cnt_next   = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> rtl/chbt_key_ram.sv
// key store, one write and one registered read port
module chbt_key_ram
(
    input  logic                       clk,
    input  chbt_pkg::ram_req_t          req,
    output logic [chbt_pkg::KEY_W-1:0] rdata
);
    import chbt_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/chained_hash_bucket_table_core.sv
// top level: sequencer, fill counts and result register of the hash bucket table
// Hash table of 31-bit keys in 16 buckets of 8 slots, bucket = key mod bucket_count.
// Input channel (in_valid/in_ready) carries action, key, read_bucket, read_slot;
// output channel (out_valid/out_ready) carries status, bucket_index, slot_key,
// bucket_fill. One result per input transfer, in order.
// cfg_we/cfg_data write bucket_count (0 taken as 1, above 16 taken as 16); write it
// only while the block is idle.
// One item is handled at a time; in_ready is high only while the sequencer waits.
// Steps from input transfer to result valid:
//   read   : key store read, then result register
//   insert : modulo unit, two remainder bits per cycle, then slot write
//   delete : modulo, then one slot compared or moved per cycle
//            through the single key store port pair
// Reset clears the fill counts and the output valid and sets bucket_count to 7;
// the key store needs no clearing since only slots below the fill are read.
// A stalled receiver holds the result in the output register; the next item may
// be taken meanwhile and waits in its last step until the register frees.
module chained_hash_bucket_table_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [chbt_pkg::CNT_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [chbt_pkg::ACTION_W-1:0] action,
    input  logic [chbt_pkg::KEY_W-1:0]    key,
    input  logic [chbt_pkg::BUCKET_W-1:0] read_bucket,
    input  logic [chbt_pkg::SLOT_W-1:0]   read_slot,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [chbt_pkg::STATUS_W-1:0] status,
    output logic [chbt_pkg::BUCKET_W-1:0] bucket_index,
    output logic [chbt_pkg::KEY_W-1:0]    slot_key,
    output logic [chbt_pkg::FILL_W-1:0]   bucket_fill
);
    import chbt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MOD    = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_READ   = 7'b0001000,
        S_SCMP   = 7'b0010000,
        S_SHWR   = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    bcount_reg;
    logic [DIV_W-1:0]    divisor;
    logic [FILL_W-1:0]   fill_reg [MAX_BUCKETS];
    logic                fill_we;
    logic [FILL_W-1:0]   fill_wdata;
    logic [FILL_W-1:0]   fill_cur;
    logic                is_read_reg, is_read_next;
    logic                is_ins_reg, is_ins_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [SLOT_W-1:0]   rslot_reg, rslot_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [FILL_W-1:0]   idx_inc;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [FILL_W-1:0]   res_fill_reg, res_fill_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_load;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BUCKET_W-1:0] out_bucket_reg;
    logic [KEY_W-1:0]    out_key_reg;
    logic [FILL_W-1:0]   out_fill_reg;
    logic                in_xfer;
    mod_req_t            mod_req;
    mod_rsp_t            mod_rsp;
    ram_req_t            ram_req;
    logic [KEY_W-1:0]    ram_rdata;

    chbt_mod_unit u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    chbt_key_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (bcount_reg == '0)
        begin
            divisor = DIV_W'(1);
        end
        else if (bcount_reg > CNT_W'(MAX_BUCKETS))
        begin
            divisor = DIV_W'(MAX_BUCKETS);
        end
        else
        begin
            divisor = bcount_reg[DIV_W-1:0];
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign fill_cur = fill_reg[bucket_reg];
    assign idx_inc  = {1'b0, idx_reg} + FILL_W'(1);
    assign out_load = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    assign mod_req.start    = in_xfer && !action[1];
    assign mod_req.dividend = key;
    assign mod_req.divisor  = divisor;

    always_comb
    begin
        state_next      = state_reg;
        is_read_next    = is_read_reg;
        is_ins_next     = is_ins_reg;
        key_next        = key_reg;
        rslot_next      = rslot_reg;
        bucket_next     = bucket_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_fill_next   = res_fill_reg;
        fill_we         = 1'b0;
        fill_wdata      = fill_cur;
        ram_req.we      = 1'b0;
        ram_req.waddr   = {bucket_reg, idx_reg};
        ram_req.wdata   = ram_rdata;
        ram_req.raddr   = {bucket_reg, idx_inc[SLOT_W-1:0]};
        case (state_reg)
            S_IDLE:
            begin
                ram_req.raddr = {read_bucket, read_slot};
                if (in_xfer)
                begin
                    is_read_next = action[1];
                    is_ins_next  = (action == ACT_INSERT);
                    key_next     = key;
                    rslot_next   = read_slot;
                    bucket_next  = read_bucket;
                    state_next   = action[1] ? S_READ : S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    bucket_next = mod_rsp.rem;
                    state_next  = S_DECIDE;
                end
            end
            S_READ:
            begin
                res_fill_next = fill_cur;
                if ({1'b0, rslot_reg} < fill_cur)
                begin
                    res_status_next = ST_OK;
                    res_key_next    = ram_rdata;
                end
                else
                begin
                    res_status_next = ST_EMPTY;
                    res_key_next    = '0;
                end
                state_next = S_RESP;
            end
            S_DECIDE:
            begin
                res_key_next  = '0;
                res_fill_next = fill_cur;
                idx_next      = '0;
                ram_req.raddr = {bucket_reg, {SLOT_W{1'b0}}};
                if (is_ins_reg)
                begin
                    if (fill_cur >= FILL_W'(SLOTS))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_req.we      = 1'b1;
                        ram_req.waddr   = {bucket_reg, fill_cur[SLOT_W-1:0]};
                        ram_req.wdata   = key_reg;
                        fill_we         = 1'b1;
                        fill_wdata      = fill_cur + FILL_W'(1);
                        res_fill_next   = fill_wdata;
                        res_status_next = ST_OK;
                    end
                    state_next = S_RESP;
                end
                else if (fill_cur == '0)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    res_status_next = ST_OK;
                    if (idx_inc >= fill_cur)
                    begin
                        fill_we       = 1'b1;
                        fill_wdata    = fill_cur - FILL_W'(1);
                        res_fill_next = fill_wdata;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SHWR;
                    end
                end
                else if (idx_inc >= fill_cur)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    idx_next = idx_inc[SLOT_W-1:0];
                end
            end
            S_SHWR:
            begin
                ram_req.we    = 1'b1;
                idx_next      = idx_inc[SLOT_W-1:0];
                ram_req.raddr = {bucket_reg, idx_inc[SLOT_W-1:0]} + ADDR_W'(1);
                if ((idx_inc + FILL_W'(1)) >= fill_cur)
                begin
                    fill_we       = 1'b1;
                    fill_wdata    = fill_cur - FILL_W'(1);
                    res_fill_next = fill_wdata;
                    state_next    = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bcount_reg    <= BUCKET_COUNT_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_BUCKETS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                bcount_reg <= cfg_data;
            end
            if (fill_we)
            begin
                fill_reg[bucket_reg] <= fill_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_read_reg    <= is_read_next;
        is_ins_reg     <= is_ins_next;
        key_reg        <= key_next;
        rslot_reg      <= rslot_next;
        bucket_reg     <= bucket_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_fill_reg   <= res_fill_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_bucket_reg <= bucket_reg;
            out_key_reg    <= is_read_reg ? res_key_reg : '0;
            out_fill_reg   <= res_fill_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign bucket_index = out_bucket_reg;
    assign slot_key     = out_key_reg;
    assign bucket_fill  = out_fill_reg;

    // one item in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input taken while an item is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (state_reg == S_MOD))
        else $error("modulo result outside the modulo step");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (state_reg == S_DECIDE || state_reg == S_SHWR))
        else $error("key store written outside insert or shift");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> (fill_wdata <= FILL_W'(SLOTS)))
        else $error("bucket fill beyond slot count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("loaded result not presented");

endmodule
